// File: design/wnm_pkg.sv
`default_nettype none

package wnm_pkg;

	// Pattern capacity and the width of a length that can hold it
	localparam int MAX_PATTERN = 32;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

	// Request kinds
	typedef enum logic [2:0] {
		KIND_START = 3'd0,
		KIND_PBYTE = 3'd1,
		KIND_PNULL = 3'd2,
		KIND_NBYTE = 3'd3,
		KIND_NNULL = 3'd4
	} kind_t;

	// Characters with a special meaning
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_QMARK   = 8'h3F;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	// Per-cycle commands broadcast along the cell chain
	typedef struct packed {
		logic restart;  // active set back to position zero
		logic advance;  // step the active set by one name byte
		logic load;     // store the request byte at the fill position
	} chain_ctl_t;

	// ASCII lower case folds to upper case
	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/wildcard_name_matcher.sv
// Wildcard name matcher.
// Request channel (req_valid/req_ready) carries kind and symbol: start pattern,
// pattern byte, null pattern, name byte, or null name. Load a pattern first
// ('*' any run, '?' one byte, letters case-insensitive; byte 0 or '/' closes
// it), then stream name bytes. A name byte of 0 or a null name produces one
// result on the result channel (res_valid/res_ready): matched and
// pattern_overflow. Patterns longer than 32 bytes are truncated and flagged.
// The pattern cells update the active position set for one name byte per clock
// while requests are accepted, and the result is registered, so it appears the
// cycle after the ending request is accepted. Throughput is one request per
// cycle while req_ready is high. The output register lets a new request enter
// while a result is being taken; if the receiver stalls with a result held,
// req_ready drops until that result is accepted.
// Reset clears the pattern (empty, open), all flags and the result valid flag;
// the active set holds only position zero. No clearing pass is needed.
`default_nettype none

module wildcard_name_matcher (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire logic [2:0] kind,
	input  wire logic [7:0] symbol,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic            matched,
	output logic            pattern_overflow
);

	logic [wnm_pkg::LEN_W-1:0]     len_q;
	logic                          closed_q;
	logic                          all_q;
	logic                          ovf_q;
	logic                          res_valid_q;
	logic                          matched_q;
	logic                          res_ovf_q;
	logic [wnm_pkg::MAX_PATTERN:0] clos;
	wnm_pkg::chain_ctl_t           ctl;
	logic                          accept;
	logic                          emit;
	logic                          hit;
	logic                          is_term;
	logic                          room;

	assign req_ready = ~res_valid_q | res_ready;
	assign accept    = req_valid & req_ready;
	assign is_term   = (symbol == wnm_pkg::CHAR_NUL) || (symbol == wnm_pkg::CHAR_SLASH);
	assign room      = (len_q < wnm_pkg::LEN_W'(wnm_pkg::MAX_PATTERN));

	// Decode the request into chain commands and a result strobe
	always_comb begin
		ctl  = '0;
		emit = 1'b0;
		hit  = 1'b0;
		if (accept) begin
			case (wnm_pkg::kind_t'(kind))
				wnm_pkg::KIND_START: begin
					ctl.restart = 1'b1;
				end
				wnm_pkg::KIND_PBYTE: begin
					if (!closed_q) begin
						ctl.restart = 1'b1;
						ctl.load    = ~is_term & room;
					end
				end
				wnm_pkg::KIND_PNULL: begin
					ctl.restart = 1'b1;
				end
				wnm_pkg::KIND_NBYTE: begin
					if (symbol != wnm_pkg::CHAR_NUL) begin
						ctl.advance = 1'b1;
					end else begin
						ctl.restart = 1'b1;
						emit        = 1'b1;
						hit         = all_q | clos[len_q];
					end
				end
				wnm_pkg::KIND_NNULL: begin
					ctl.restart = 1'b1;
					emit        = 1'b1;
					hit         = all_q;
				end
				default: begin
					ctl = '0;
				end
			endcase
		end
	end

	// Pattern bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			closed_q <= 1'b0;
			all_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			case (wnm_pkg::kind_t'(kind))
				wnm_pkg::KIND_START: begin
					len_q    <= '0;
					closed_q <= 1'b0;
					all_q    <= 1'b0;
					ovf_q    <= 1'b0;
				end
				wnm_pkg::KIND_PBYTE: begin
					if (!closed_q) begin
						if (is_term) begin
							closed_q <= 1'b1;
						end else if (room) begin
							len_q <= len_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				wnm_pkg::KIND_PNULL: begin
					len_q    <= '0;
					closed_q <= 1'b1;
					all_q    <= 1'b1;
					ovf_q    <= 1'b0;
				end
				default: begin
					len_q <= len_q;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			matched_q <= hit;
			res_ovf_q <= ovf_q;
		end
	end

	assign res_valid        = res_valid_q;
	assign matched          = matched_q;
	assign pattern_overflow = res_ovf_q;

	wnm_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sym    (symbol),
		.len    (len_q),
		.clos   (clos)
	);

endmodule

`default_nettype wire

// File: design/wnm_cell.sv
`default_nettype none

// One pattern position: holds pattern byte i and the active bit of position i+1.
module wnm_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire wnm_pkg::chain_ctl_t ctl,
	input  wire logic [7:0]          sym,
	input  wire logic                sel,       // this cell is the fill position
	input  wire logic                occ,       // byte is inside the stored pattern
	input  wire logic                clos_in,   // position i reachable, closure applied
	input  wire logic                stay_nxt,  // next cell keeps its star active
	output logic                     clos_out,  // position i+1 reachable, closure applied
	output logic                     stay_out   // this star keeps position i active
);

	logic [7:0] byte_q;
	logic       act_q;
	logic       is_star;
	logic       hit;
	logic       step;

	// Local compare against the streamed name byte
	assign is_star  = (byte_q == wnm_pkg::CHAR_STAR);
	assign hit      = (byte_q == wnm_pkg::CHAR_QMARK) ||
	                  (wnm_pkg::fold_case(byte_q) == wnm_pkg::fold_case(sym));
	assign stay_out = clos_in & occ & is_star;
	assign step     = clos_in & occ & ~is_star & hit;
	assign clos_out = act_q | stay_out;

	// Pattern byte storage
	always_ff @(posedge clk) begin
		if (ctl.load && sel) begin
			byte_q <= sym;
		end
	end

	// Active bit for position i+1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (ctl.restart) begin
			act_q <= 1'b0;
		end else if (ctl.advance) begin
			act_q <= step | stay_nxt;
		end
	end

endmodule

`default_nettype wire

// File: design/wnm_chain.sv
`default_nettype none

// Row of pattern cells plus the position-zero active bit.
module wnm_chain (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire wnm_pkg::chain_ctl_t              ctl,
	input  wire logic [7:0]                       sym,
	input  wire logic [wnm_pkg::LEN_W-1:0]        len,
	output logic      [wnm_pkg::MAX_PATTERN:0]    clos
);

	logic                            act0_q;
	logic [wnm_pkg::MAX_PATTERN:0]   stay;
	logic [wnm_pkg::MAX_PATTERN-1:0] occ;
	logic [wnm_pkg::MAX_PATTERN-1:0] sel;

	// Position zero has no cell of its own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act0_q <= 1'b1;
		end else if (ctl.restart) begin
			act0_q <= 1'b1;
		end else if (ctl.advance) begin
			act0_q <= stay[0];
		end
	end

	assign clos[0]                       = act0_q;
	assign stay[wnm_pkg::MAX_PATTERN]    = 1'b0;

	for (genvar g = 0; g < wnm_pkg::MAX_PATTERN; g++) begin : g_cell
		assign occ[g] = (wnm_pkg::LEN_W'(g) < len);
		assign sel[g] = (wnm_pkg::LEN_W'(g) == len);

		wnm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sym      (sym),
			.sel      (sel[g]),
			.occ      (occ[g]),
			.clos_in  (clos[g]),
			.stay_nxt (stay[g+1]),
			.clos_out (clos[g+1]),
			.stay_out (stay[g])
		);
	end

endmodule

`default_nettype wire

// File: verif/testbench.sv
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1900;
	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 4;

	// Kinds the block has no use for
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

	// Active set holding only position zero
	localparam logic [wnm_pkg::MAX_PATTERN:0] SET_ORIGIN = {{wnm_pkg::MAX_PATTERN{1'b0}}, 1'b1};

	typedef struct packed {
		logic hit;
		logic ovf;
	} verdict_t;

	typedef struct packed {
		logic [2:0] k;
		logic [7:0] s;
		logic       fixed;
		verdict_t   want;
	} stim_row_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	logic [2:0] kind = wnm_pkg::KIND_START;
	logic [7:0] symbol = wnm_pkg::CHAR_NUL;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic       matched;
	logic       pattern_overflow;

	// Mirror of the matcher state
	logic [7:0]                    pat_mem [wnm_pkg::MAX_PATTERN];
	int                            pat_len;
	logic                          pat_closed;
	logic                          match_all;
	logic                          ovf_seen;
	logic [wnm_pkg::MAX_PATTERN:0] active_set;

	verdict_t verdict_q[$];

	int send_idle = 32;
	int recv_idle = 49;
	int req_sent;
	int fault_count;
	int verdicts_seen;
	int hits_seen;
	int ovf_results;
	int stall_count;

	wildcard_name_matcher uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_valid        (req_valid),
		.req_ready        (req_ready),
		.kind             (kind),
		.symbol           (symbol),
		.res_valid        (res_valid),
		.res_ready        (res_ready),
		.matched          (matched),
		.pattern_overflow (pattern_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] upcase(input logic [7:0] c);
		if (c >= "a" && c <= "z") begin
			return c - wnm_pkg::CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Reachable positions plus everything a star lets us skip to
	function automatic logic [wnm_pkg::MAX_PATTERN:0] with_stars(
			input logic [wnm_pkg::MAX_PATTERN:0] set);
		for (int i = 0; i < pat_len; i++) begin
			if (set[i] && pat_mem[i] == wnm_pkg::CHAR_STAR) begin
				set[i + 1] = 1'b1;
			end
		end
		return set;
	endfunction

	// Applies one request to the mirror; returns 1 when it ends a name
	function automatic bit evaluate_request(input logic [2:0] k, input logic [7:0] s,
			output verdict_t v);
		logic [wnm_pkg::MAX_PATTERN:0] cur;
		logic [wnm_pkg::MAX_PATTERN:0] nxt;
		v = '0;
		case (k)
			wnm_pkg::KIND_START: begin
				pat_len    = 0;
				pat_closed = 1'b0;
				match_all  = 1'b0;
				ovf_seen   = 1'b0;
				active_set = SET_ORIGIN;
				return 0;
			end
			wnm_pkg::KIND_PBYTE: begin
				if (pat_closed) begin
					return 0;
				end
				active_set = SET_ORIGIN;
				if (s == wnm_pkg::CHAR_NUL || s == wnm_pkg::CHAR_SLASH) begin
					pat_closed = 1'b1;
				end else if (pat_len < wnm_pkg::MAX_PATTERN) begin
					pat_mem[pat_len] = s;
					pat_len++;
				end else begin
					ovf_seen = 1'b1;
				end
				return 0;
			end
			wnm_pkg::KIND_PNULL: begin
				pat_len    = 0;
				pat_closed = 1'b1;
				match_all  = 1'b1;
				ovf_seen   = 1'b0;
				active_set = SET_ORIGIN;
				return 0;
			end
			wnm_pkg::KIND_NBYTE: begin
				cur = with_stars(active_set);
				if (s != wnm_pkg::CHAR_NUL) begin
					nxt = '0;
					for (int i = 0; i < pat_len; i++) begin
						if (cur[i]) begin
							if (pat_mem[i] == wnm_pkg::CHAR_STAR) begin
								nxt[i] = 1'b1;
							end else if (pat_mem[i] == wnm_pkg::CHAR_QMARK ||
									upcase(pat_mem[i]) == upcase(s)) begin
								nxt[i + 1] = 1'b1;
							end
						end
					end
					active_set = nxt;
					return 0;
				end
				v.hit = match_all || cur[pat_len];
			end
			wnm_pkg::KIND_NNULL: begin
				v.hit = match_all;
			end
			default: begin
				return 0;
			end
		endcase
		v.ovf      = ovf_seen;
		active_set = SET_ORIGIN;
		return 1;
	endfunction

	// Drive one request, wait for the handshake, then log what it should produce
	task automatic send_request(input logic [2:0] k, input logic [7:0] s,
			input bit fixed = 0, input verdict_t want = '0);
		verdict_t v;
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind      <= k;
		symbol    <= s;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		req_sent++;
		if (evaluate_request(k, s, v)) begin
			verdict_q.push_back(fixed ? want : v);
		end
	endtask

	function automatic logic [7:0] pattern_char();
		int r;
		r = $urandom_range(99);
		if (r < 20) begin
			return wnm_pkg::CHAR_STAR;
		end else if (r < 35) begin
			return wnm_pkg::CHAR_QMARK;
		end else if (r < 85) begin
			case ($urandom_range(3))
				0: return "a";
				1: return "b";
				2: return "A";
				default: return "B";
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] name_char();
		if ($urandom_range(99) < 70) begin
			return ($urandom_range(1)) ? "a" : "B";
		end
		return 8'($urandom_range(1, 255));
	endfunction

	// New pattern: start, bytes, then usually a terminator and sometimes a stray byte after it
	task automatic load_pattern();
		int len;
		int r;
		r = $urandom_range(99);
		if (r < 85) begin
			len = $urandom_range(8);
		end else if (r < 95) begin
			len = $urandom_range(wnm_pkg::MAX_PATTERN - 2, wnm_pkg::MAX_PATTERN + 2);
		end else begin
			len = $urandom_range(wnm_pkg::MAX_PATTERN + 3, wnm_pkg::MAX_PATTERN + 8);
		end
		send_request(wnm_pkg::KIND_START, 8'($urandom_range(255)));
		for (int i = 0; i < len; i++) begin
			send_request(wnm_pkg::KIND_PBYTE, pattern_char());
		end
		if ($urandom_range(99) < 70) begin
			send_request(wnm_pkg::KIND_PBYTE,
				($urandom_range(1)) ? wnm_pkg::CHAR_SLASH : wnm_pkg::CHAR_NUL);
			if ($urandom_range(99) < 20) begin
				send_request(wnm_pkg::KIND_PBYTE, pattern_char());
			end
		end
	endtask

	// Name usually built from the stored pattern, so that many of them match
	task automatic send_name();
		logic [7:0] c;
		if ($urandom_range(99) < 65) begin
			for (int i = 0; i < pat_len; i++) begin
				c = pat_mem[i];
				if (c == wnm_pkg::CHAR_STAR) begin
					repeat ($urandom_range(3)) send_request(wnm_pkg::KIND_NBYTE, name_char());
					continue;
				end
				if (c == wnm_pkg::CHAR_QMARK) begin
					c = 8'($urandom_range(1, 255));
				end else if (is_letter(c) && $urandom_range(1)) begin
					c = c ^ wnm_pkg::CASE_OFFSET;
				end
				if ($urandom_range(99) < 3) begin
					c = name_char();
				end
				send_request(wnm_pkg::KIND_NBYTE, c);
			end
		end else begin
			repeat ($urandom_range(6)) send_request(wnm_pkg::KIND_NBYTE, name_char());
		end
		if ($urandom_range(99) < 90) begin
			send_request(wnm_pkg::KIND_NBYTE, wnm_pkg::CHAR_NUL);
		end else begin
			send_request(wnm_pkg::KIND_NNULL, 8'($urandom_range(255)));
		end
	endtask

	// Result side: random back-pressure
	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_idle);
	end

	// Compare each result with the oldest expected verdict
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && res_valid && res_ready) begin
			verdicts_seen++;
			hits_seen   += matched;
			ovf_results += pattern_overflow;
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual matched=%0b overflow=%0b",
					$time, matched, pattern_overflow);
				fault_count++;
			end else begin
				want = verdict_q.pop_front();
				if (matched !== want.hit) begin
					$display("%0t: matched mismatch, expected %0b, actual %0b",
						$time, want.hit, matched);
					fault_count++;
				end
				if (pattern_overflow !== want.ovf) begin
					$display("%0t: pattern_overflow mismatch, expected %0b, actual %0b",
						$time, want.ovf, pattern_overflow);
					fault_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (res_valid && res_ready)) begin
				stall_count = 0;
			end else begin
				stall_count++;
			end
			if (stall_count >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, verdict_q.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		stim_row_t directed_rows [25];
		int total;
		int r;
		directed_rows = '{
			'{wnm_pkg::KIND_NNULL, wnm_pkg::CHAR_NUL,   1'b1, '{1'b0, 1'b0}},
			'{wnm_pkg::KIND_NBYTE, 8'hFF,               1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, wnm_pkg::CHAR_NUL,   1'b0, '0},
			'{wnm_pkg::KIND_PNULL, 8'hFF,               1'b0, '0},
			'{wnm_pkg::KIND_NNULL, wnm_pkg::CHAR_NUL,   1'b1, '{1'b1, 1'b0}},
			'{wnm_pkg::KIND_START, wnm_pkg::CHAR_NUL,   1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, "a",                 1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, wnm_pkg::CHAR_STAR,  1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, wnm_pkg::CHAR_QMARK, 1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, "Z",                 1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, wnm_pkg::CHAR_SLASH, 1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, "q",                 1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, "A",                 1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, "x",                 1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, "y",                 1'b0, '0},
			'{KIND_UNUSED_LAST,    8'hFF,               1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, "z",                 1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, wnm_pkg::CHAR_NUL,   1'b0, '0},
			'{wnm_pkg::KIND_NNULL, 8'hFF,               1'b1, '{1'b0, 1'b0}},
			'{wnm_pkg::KIND_NBYTE, "a",                 1'b0, '0},
			'{wnm_pkg::KIND_START, 8'hFF,               1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, 8'hFF,               1'b0, '0},
			'{wnm_pkg::KIND_PBYTE, wnm_pkg::CHAR_NUL,   1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, 8'hFF,               1'b0, '0},
			'{wnm_pkg::KIND_NBYTE, wnm_pkg::CHAR_NUL,   1'b0, '0}
		};

		pat_len    = 0;
		pat_closed = 1'b0;
		match_all  = 1'b0;
		ovf_seen   = 1'b0;
		active_set = SET_ORIGIN;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests
		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].k, directed_rows[i].s,
				directed_rows[i].fixed, directed_rows[i].want);
		end

		// Random sequences; idling pattern changes every third of the run
		total = req_sent + RANDOM_ITEMS;
		while (req_sent < total) begin
			case ((3 * (req_sent - total + RANDOM_ITEMS)) / RANDOM_ITEMS)
				0: begin
					send_idle = 32;
					recv_idle = 49;
				end
				1: begin
					send_idle = 49;
					recv_idle = 32;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			r = $urandom_range(99);
			if (r < 6) begin
				send_request(wnm_pkg::KIND_PNULL, 8'($urandom_range(255)));
			end else if (r < 30) begin
				load_pattern();
			end else if (r < 90) begin
				send_name();
			end else if (r < 95) begin
				send_request(3'($urandom_range(KIND_UNUSED_LAST)), 8'($urandom_range(255)));
			end else begin
				send_request(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)),
					8'($urandom_range(255)));
			end
		end
		req_valid <= 1'b0;

		// Drain, then wait out SETTLE_CYCLES to catch stray results
		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests across three idling phases; %0d results checked.",
			req_sent, verdicts_seen);
		$display("Results with a match: %0d, with pattern truncation: %0d, errors: %0d.",
			hits_seen, ovf_results, fault_count);
		if (fault_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
